// ===== hdl/kvsl_pkg.sv =====
// Shared types, constants and register map of the key/value string lookup block.
package kvsl_pkg;

  localparam int KVSL_MAX_KEY_LEN = 8;
  localparam int KVSL_MAX_DELIMS  = 4;

  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;

  localparam logic [7:0] CHAR_EQ  = 8'h3D;
  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_CR  = 8'h0D;

  typedef enum logic [2:0] {
    REG_KEY_CHARS       = 3'd0,
    REG_KEY_LENGTH      = 3'd1,
    REG_DELIMITER_CHARS = 3'd2,
    REG_DELIMITER_COUNT = 3'd3,
    REG_VALUE_LIMIT     = 3'd4
  } reg_idx_t;

  typedef enum logic [5:0] {
    PH_BETWEEN = 6'b000001,
    PH_LEADWS  = 6'b000010,
    PH_KEYPART = 6'b000100,
    PH_SKIP    = 6'b001000,
    PH_VALUE   = 6'b010000,
    PH_DONE    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic        is_summary;
    logic [7:0]  value_byte;
    logic        found;
    logic [11:0] value_length;
  } out_word_t;

  typedef struct packed {
    logic [63:0] key_chars;
    logic [3:0]  key_length;
    logic [31:0] delimiter_chars;
    logic [2:0]  delimiter_count;
    logic [11:0] value_limit;
  } cfg_t;

endpackage

// ===== hdl/kvsl_cfg.sv =====
// APB-style configuration register file of the key/value string lookup block.
module kvsl_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [kvsl_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [kvsl_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [kvsl_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output kvsl_pkg::cfg_t                   cfg
);
  import kvsl_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_KEY_CHARS:       cfg_nxt.key_chars       = pwdata;
        REG_KEY_LENGTH:      cfg_nxt.key_length      = pwdata[3:0];
        REG_DELIMITER_CHARS: cfg_nxt.delimiter_chars = pwdata[31:0];
        REG_DELIMITER_COUNT: cfg_nxt.delimiter_count = pwdata[2:0];
        REG_VALUE_LIMIT:     cfg_nxt.value_limit     = pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KEY_CHARS:       prdata = cfg_r.key_chars;
      REG_KEY_LENGTH:      prdata = {60'd0, cfg_r.key_length};
      REG_DELIMITER_CHARS: prdata = {32'd0, cfg_r.delimiter_chars};
      REG_DELIMITER_COUNT: prdata = {61'd0, cfg_r.delimiter_count};
      REG_VALUE_LIMIT:     prdata = {52'd0, cfg_r.value_limit};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_chars       <= '0;
      cfg_r.key_length      <= '0;
      cfg_r.delimiter_chars <= '0;
      cfg_r.delimiter_count <= 3'd1;
      cfg_r.value_limit     <= 12'd255;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== hdl/kvsl_scan.sv =====
// Input register and per-byte token scanner of the key/value string lookup block.
module kvsl_scan #(
  parameter int MAX_KEY_LEN = kvsl_pkg::KVSL_MAX_KEY_LEN,
  parameter int MAX_DELIMS  = kvsl_pkg::KVSL_MAX_DELIMS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kvsl_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  kvsl_pkg::in_word_t  in_word,
  input  logic                res_ready,
  output logic                res_valid,
  output kvsl_pkg::out_word_t res_word
);
  import kvsl_pkg::*;

  localparam int KLIM = (MAX_KEY_LEN < 8) ? MAX_KEY_LEN : 8;
  localparam int DLIM = (MAX_DELIMS < 4) ? MAX_DELIMS : 4;

  logic        s1_valid_r, s1_valid_nxt;
  in_word_t    s1_word_r;
  phase_t      phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic        match_r, match_nxt;
  logic [11:0] emitted_r, emitted_nxt;
  logic        found_r, found_nxt;

  logic        accept;
  logic        fire;
  logic [7:0]  c;
  logic [3:0]  key_len;
  logic        is_delim;
  logic        is_ws;
  logic [7:0]  key_byte;

  assign accept   = in_valid && !in_stall;
  assign fire     = s1_valid_r && res_ready;
  assign in_stall = s1_valid_r && !res_ready;
  assign c        = s1_word_r.text_byte;
  assign is_ws    = (c == CHAR_SP) || (c >= CHAR_TAB && c <= CHAR_CR);
  assign key_byte = cfg.key_chars[8*pos_r[2:0] +: 8];

  always_comb begin
    logic [3:0] n;
    logic       stop;
    n       = (cfg.key_length > 4'(KLIM)) ? 4'(KLIM) : cfg.key_length;
    key_len = n;
    stop    = 1'b0;
    for (int i = 0; i < KLIM; i++) begin
      if (!stop && 4'(i) < n && cfg.key_chars[8*i +: 8] == CHAR_NUL) begin
        key_len = 4'(i);
        stop    = 1'b1;
      end
    end
  end

  always_comb begin
    logic [2:0] n;
    logic       alive;
    n        = (cfg.delimiter_count > 3'(DLIM)) ? 3'(DLIM) : cfg.delimiter_count;
    alive    = 1'b1;
    is_delim = 1'b0;
    for (int i = 0; i < DLIM; i++) begin
      if (alive && 3'(i) < n) begin
        if (cfg.delimiter_chars[8*i +: 8] == CHAR_NUL) begin
          alive = 1'b0;
        end else if (cfg.delimiter_chars[8*i +: 8] == c) begin
          is_delim = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic key_step;
    key_step     = 1'b0;
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    match_nxt    = match_r;
    emitted_nxt  = emitted_r;
    found_nxt    = found_r;
    res_valid    = 1'b0;
    res_word     = '0;
    if (fire) begin
      if (s1_word_r.end_of_text) begin
        res_valid              = 1'b1;
        res_word.is_summary    = 1'b1;
        res_word.found         = found_r;
        res_word.value_length  = emitted_r;
        phase_nxt              = PH_BETWEEN;
        pos_nxt                = '0;
        match_nxt              = 1'b1;
        emitted_nxt            = '0;
        found_nxt              = 1'b0;
      end else if (phase_r == PH_DONE) begin
        phase_nxt = PH_DONE;
      end else if (c == CHAR_NUL) begin
        phase_nxt = PH_DONE;
      end else if (is_delim) begin
        if (phase_r == PH_VALUE) begin
          phase_nxt = PH_DONE;
        end else begin
          phase_nxt = PH_BETWEEN;
          pos_nxt   = '0;
          match_nxt = 1'b1;
        end
      end else begin
        unique case (phase_r)
          PH_BETWEEN, PH_LEADWS: begin
            if (is_ws) begin
              phase_nxt = PH_LEADWS;
            end else begin
              phase_nxt = PH_KEYPART;
              key_step  = 1'b1;
            end
          end
          PH_KEYPART: key_step = 1'b1;
          PH_VALUE: begin
            if (emitted_r < cfg.value_limit) begin
              emitted_nxt         = emitted_r + 12'd1;
              res_valid           = 1'b1;
              res_word.value_byte = c;
            end
          end
          default: ;
        endcase
        if (key_step) begin
          if (c == CHAR_EQ) begin
            if (match_r) begin
              found_nxt = 1'b1;
              phase_nxt = PH_VALUE;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end else if (pos_r >= key_len) begin
            match_nxt = 1'b0;
          end else begin
            if (key_byte != c) begin
              match_nxt = 1'b0;
            end
            pos_nxt = pos_r + 4'd1;
          end
        end
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      phase_r    <= PH_BETWEEN;
      pos_r      <= '0;
      match_r    <= 1'b1;
      emitted_r  <= '0;
      found_r    <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      match_r    <= match_nxt;
      emitted_r  <= emitted_nxt;
      found_r    <= found_nxt;
    end
  end

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && phase_r == PH_DONE && !s1_word_r.end_of_text) |=> phase_r == PH_DONE)
    else $error("scan left the done phase without a terminator");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= 4'(KLIM))
    else $error("key position ran past the key length limit");

  a_byte_in_value: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_word.is_summary) |-> phase_r == PH_VALUE)
    else $error("value byte emitted outside a value");

  a_summary_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_word_r.end_of_text) |=> (emitted_r == 12'd0 && !found_r && match_r))
    else $error("terminator did not clear the scan state");

endmodule

// ===== hdl/kvsl_outbuf.sv =====
// Result register with skid stage of the key/value string lookup block.
module kvsl_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  kvsl_pkg::out_word_t res_word,
  output logic                res_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output kvsl_pkg::out_word_t out_word
);
  import kvsl_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;
  logic      skd_valid_r, skd_valid_nxt;
  out_word_t skd_word_r, skd_word_nxt;
  logic      drain;

  assign res_ready = !skd_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign drain     = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    skd_valid_nxt = skd_valid_r;
    skd_word_nxt  = skd_word_r;
    if (drain) begin
      if (skd_valid_r) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = skd_word_r;
        skd_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_word_nxt  = res_word;
      end
    end else if (res_valid && res_ready) begin
      skd_valid_nxt = 1'b1;
      skd_word_nxt  = res_word;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    skd_word_r <= skd_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skd_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skd_valid_r <= skd_valid_nxt;
    end
  end

  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skd_valid_r |-> out_valid_r)
    else $error("skid word held with an empty result register");

endmodule

// ===== hdl/key_value_string_lookup.sv =====
// Top level of the key/value string lookup block.
// Usage: the input channel (in_valid, in_stall, in_word) takes one text word per
// cycle while in_stall is low: a text byte, or a terminator with end_of_text set.
// Bytes are cut into tokens by the configured delimiters; the value bytes of the
// first token whose key part is a prefix of the configured key leave on the result
// channel (out_valid, out_stall, out_word), one word per byte, up to value_limit
// of them. A terminator yields one summary word with found and value_length, and
// rearms the scan for the next text. A word is registered at the input and scanned
// there once the result side is ready; its result goes to the result register, or
// to the skid stage while out_stall holds that register. Throughput: one word per
// cycle while in_stall is low, set by the combinational scan step between input
// and result registers. Stall: a result register and a one-word skid stage hold
// results while out_stall is high; in_stall rises once the skid stage is occupied
// while the input register holds a word.
// Reset (rst_n low, synchronous) empties all stages, returns the scan to
// between tokens and loads register defaults (delimiter_count 1,
// value_limit 255, others zero). Registers are written over the APB-style
// port at byte address 8*index and should be written only while idle.
module key_value_string_lookup #(
  parameter int MAX_KEY_LEN = kvsl_pkg::KVSL_MAX_KEY_LEN,
  parameter int MAX_DELIMS  = kvsl_pkg::KVSL_MAX_DELIMS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  kvsl_pkg::in_word_t               in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output kvsl_pkg::out_word_t              out_word,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [kvsl_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [kvsl_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [kvsl_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import kvsl_pkg::*;

  cfg_t      cfg;
  logic      res_valid;
  logic      res_ready;
  out_word_t res_word;

  kvsl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kvsl_scan #(
    .MAX_KEY_LEN (MAX_KEY_LEN),
    .MAX_DELIMS  (MAX_DELIMS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  kvsl_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_word  (res_word),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
